// ===== rtl/core/xcs_pkg.sv =====
// ----------------------------------------------------------------------------
// xcs_pkg
// Types and constants shared by the XMODEM checksum sender modules.
// ----------------------------------------------------------------------------
`default_nettype none

package xcs_pkg;

	// Fixed frame geometry.
	localparam int unsigned BLOCK_BYTES = 128;
	localparam logic [7:0]  FRAME_BYTES = 8'(BLOCK_BYTES + 4);
	localparam logic [7:0]  DATA_FIRST  = 8'd3;
	localparam logic [7:0]  DATA_END    = 8'(BLOCK_BYTES + 3);
	localparam logic [7:0]  BLOCK_CHUNK = 8'(BLOCK_BYTES);

	// Protocol bytes.
	localparam logic [7:0] BYTE_SOH = 8'h01;
	localparam logic [7:0] BYTE_EOT = 8'h04;
	localparam logic [7:0] BYTE_ACK = 8'h06;
	localparam logic [7:0] BYTE_NAK = 8'h15;
	localparam logic [7:0] BYTE_CAN = 8'h18;
	localparam logic [7:0] PAD_BYTE = 8'h1A;

	localparam logic [7:0] DEFAULT_TIMEOUT = 8'd60;

	// Configuration register indexes.
	localparam logic [1:0] REG_START_OFFSET  = 2'd0;
	localparam logic [1:0] REG_AREA_LENGTH   = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_TICK = 2'd1,
		OP_RECV = 2'd2,
		OP_PULL = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_DONE    = 2'd1,
		EV_TIMEOUT = 2'd2,
		EV_CANCEL  = 2'd3
	} ev_t;

	// Where the transmitted byte comes from once the store data is back.
	typedef enum logic [1:0] {
		SRC_CONST = 2'd0,
		SRC_DATA  = 2'd1,
		SRC_SUM   = 2'd2
	} src_t;

	// One word in flight between the control stage and the output stage.
	typedef struct packed {
		logic       tx_valid;
		logic       tx_last;
		logic [7:0] tx_byte;
		src_t       src;
		logic       add_sum;
		logic       clr_sum;
		logic       phase;
		logic [7:0] block_number;
		ev_t        event_res;
	} xcs_s1_t;

endpackage

`default_nettype wire

// ===== rtl/core/xcs_ram.sv =====
// ----------------------------------------------------------------------------
// xcs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module xcs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/xcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// xcs_ctrl
// Configuration registers, transfer state and first pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module xcs_ctrl import xcs_pkg::*; #(
	parameter int unsigned AW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [16:0]   cfg_data,
	input  wire logic          accept,
	input  wire logic          s1_hold,
	input  wire logic [1:0]    operation,
	input  wire logic [7:0]    value,
	output      logic [AW-1:0] rd_addr,
	output      logic          valid_s1,
	output      xcs_s1_t       word_s1
);

	logic [15:0]   start_q;
	logic [16:0]   length_q;
	logic [7:0]    timeout_q;

	logic          phase_q,     phase_n;
	logic [7:0]    block_q,     block_n;
	logic [16:0]   remaining_q, remaining_n;
	logic [AW-1:0] rdptr_q,     rdptr_n;
	logic [7:0]    chunk_q,     chunk_n;
	logic [7:0]    elapsed_q,   elapsed_n;
	logic [7:0]    index_q,     index_n;
	logic          eot_q,       eot_n;

	logic          prep;
	logic [7:0]    frame_len;
	logic [7:0]    data_off;
	op_t           op;
	xcs_s1_t       word_c;

	assign op        = op_t'(operation);
	assign frame_len = eot_q ? 8'd1 : FRAME_BYTES;
	assign data_off  = index_q - DATA_FIRST;
	assign rd_addr   = rdptr_q + AW'(data_off);

	always_comb begin
		phase_n     = phase_q;
		block_n     = block_q;
		remaining_n = remaining_q;
		rdptr_n     = rdptr_q;
		chunk_n     = chunk_q;
		elapsed_n   = elapsed_q;
		index_n     = index_q;
		eot_n       = eot_q;
		prep        = 1'b0;
		word_c      = '0;
		word_c.src  = SRC_CONST;
		word_c.event_res = EV_NONE;

		case (op)
			OP_TICK: begin
				if (phase_q) begin
					if (elapsed_q != 8'hFF) begin
						elapsed_n = elapsed_q + 8'd1;
					end
					if (elapsed_n >= timeout_q) begin
						phase_n = 1'b0;
						word_c.event_res = EV_TIMEOUT;
					end
				end
			end
			OP_RECV: begin
				if (!phase_q) begin
					if (value == BYTE_NAK) begin
						phase_n     = 1'b1;
						block_n     = 8'd1;
						remaining_n = length_q;
						rdptr_n     = start_q[AW-1:0];
						prep        = 1'b1;
					end
				end else if (value == BYTE_ACK) begin
					if (eot_q) begin
						phase_n = 1'b0;
						word_c.event_res = EV_DONE;
					end else begin
						remaining_n = remaining_q - 17'(chunk_q);
						rdptr_n     = rdptr_q + AW'(chunk_q);
						block_n     = block_q + 8'd1;
						prep        = 1'b1;
					end
				end else if (value == BYTE_NAK) begin
					index_n        = 8'd0;
					word_c.clr_sum = 1'b1;
				end else if (value == BYTE_CAN) begin
					phase_n = 1'b0;
					word_c.event_res = EV_CANCEL;
				end
			end
			OP_PULL: begin
				if (phase_q && (index_q < frame_len)) begin
					word_c.tx_valid = 1'b1;
					word_c.tx_last  = (index_q + 8'd1 == frame_len);
					index_n         = index_q + 8'd1;
					if (eot_q) begin
						word_c.tx_byte = BYTE_EOT;
					end else if (index_q == 8'd0) begin
						word_c.tx_byte = BYTE_SOH;
					end else if (index_q == 8'd1) begin
						word_c.tx_byte = block_q;
					end else if (index_q == 8'd2) begin
						word_c.tx_byte = ~block_q;
					end else if (index_q < DATA_END) begin
						// Data bytes past the chunk are padding; both go into the sum.
						word_c.add_sum = 1'b1;
						if (data_off < chunk_q) begin
							word_c.src = SRC_DATA;
						end else begin
							word_c.tx_byte = PAD_BYTE;
						end
					end else begin
						word_c.src = SRC_SUM;
					end
				end
			end
			default: begin
			end
		endcase

		if (prep) begin
			eot_n          = (remaining_n == 17'd0);
			chunk_n        = (|remaining_n[16:7]) ? BLOCK_CHUNK : {1'b0, remaining_n[6:0]};
			index_n        = 8'd0;
			elapsed_n      = 8'd0;
			word_c.clr_sum = 1'b1;
		end

		word_c.phase        = phase_n;
		word_c.block_number = block_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= '0;
			length_q    <= '0;
			timeout_q   <= DEFAULT_TIMEOUT;
			phase_q     <= 1'b0;
			block_q     <= 8'd1;
			remaining_q <= '0;
			rdptr_q     <= '0;
			chunk_q     <= '0;
			elapsed_q   <= '0;
			index_q     <= '0;
			eot_q       <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_START_OFFSET:  start_q   <= cfg_data[15:0];
					REG_AREA_LENGTH:   length_q  <= cfg_data;
					REG_TIMEOUT_TICKS: timeout_q <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				phase_q     <= phase_n;
				block_q     <= block_n;
				remaining_q <= remaining_n;
				rdptr_q     <= rdptr_n;
				chunk_q     <= chunk_n;
				elapsed_q   <= elapsed_n;
				index_q     <= index_n;
				eot_q       <= eot_n;
			end
			valid_s1 <= accept | s1_hold;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= word_c;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/xcs_out.sv =====
// ----------------------------------------------------------------------------
// xcs_out
// Output stage: picks the frame byte, keeps the data sum, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module xcs_out import xcs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       move,
	input  wire logic       res_stall,
	input  wire xcs_s1_t    word_s1,
	input  wire logic [7:0] rd_data,
	output      logic       res_valid,
	output      logic       tx_valid,
	output      logic [7:0] tx_byte,
	output      logic       tx_last,
	output      logic       phase,
	output      logic [7:0] block_number,
	output      logic [1:0] event_res
);

	logic [7:0] sum_q;
	logic [7:0] byte_c;

	always_comb begin
		case (word_s1.src)
			SRC_DATA: byte_c = rd_data;
			SRC_SUM:  byte_c = sum_q;
			default:  byte_c = word_s1.tx_byte;
		endcase
	end

	// The sum follows the word order, so it is kept here rather than in stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			if (move) begin
				res_valid <= 1'b1;
				if (word_s1.clr_sum) begin
					sum_q <= '0;
				end else if (word_s1.add_sum) begin
					sum_q <= sum_q + byte_c;
				end
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			tx_valid     <= word_s1.tx_valid;
			tx_byte      <= byte_c;
			tx_last      <= word_s1.tx_last;
			phase        <= word_s1.phase;
			block_number <= word_s1.block_number;
			event_res    <= word_s1.event_res;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/xmodem_checksum_sender_top.sv =====
// ----------------------------------------------------------------------------
// xmodem_checksum_sender_top
// XMODEM sender with 128-byte blocks and an 8-bit checksum over a byte store.
//
// Words enter on item_valid/item_stall: load a store byte, a timer tick, a
// byte received from the far end, or a pull of the next transmit byte. Every
// word gives exactly one result word on res_valid/res_stall carrying the
// transmit byte (when tx_valid), the phase, the block number and any event.
// Set start_offset, area_length and timeout_ticks through cfg_we while idle.
//
// The edge that takes a word updates the control state, starts the store read
// and holds the word in the first stage; it moves into the output register,
// raising res_valid, once that register is free. A new word can be taken
// every cycle while the receiver keeps up.
// When the receiver stalls, the output register holds and a word already in
// the first stage waits there; item_stall is high while both are full and
// res_stall is high, and drops in the cycle the result word is taken.
// Reset leaves the block idle with block number one and a timeout of 60
// ticks. The store is not cleared; load it before a transfer reads it.
// ----------------------------------------------------------------------------
`default_nettype none

module xmodem_checksum_sender_top import xcs_pkg::*; #(
	parameter int unsigned STORE_DEPTH = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data,
	input  wire logic        item_valid,
	output      logic        item_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  value,
	output      logic        res_valid,
	input  wire logic        res_stall,
	output      logic        tx_valid,
	output      logic [7:0]  tx_byte,
	output      logic        tx_last,
	output      logic        phase,
	output      logic [7:0]  block_number,
	output      logic [1:0]  event_res
);

	localparam int unsigned AW = $clog2(STORE_DEPTH);

	logic          accept;
	logic          out_ready;
	logic          move;
	logic          valid_s1;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	xcs_s1_t       word_s1;

	assign out_ready  = !res_valid || !res_stall;
	assign move       = valid_s1 && out_ready;
	assign item_stall = valid_s1 && !out_ready;
	assign accept     = item_valid && !item_stall;

	xcs_ctrl #(
		.AW(AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.s1_hold   (item_stall),
		.operation (operation),
		.value     (value),
		.rd_addr   (rd_addr),
		.valid_s1  (valid_s1),
		.word_s1   (word_s1)
	);

	xcs_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept && (op_t'(operation) == OP_LOAD)),
		.waddr (address[AW-1:0]),
		.wdata (value),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	xcs_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.move         (move),
		.res_stall    (res_stall),
		.word_s1      (word_s1),
		.rd_data      (rd_data),
		.res_valid    (res_valid),
		.tx_valid     (tx_valid),
		.tx_byte      (tx_byte),
		.tx_last      (tx_last),
		.phase        (phase),
		.block_number (block_number),
		.event_res    (event_res)
	);

endmodule

`default_nettype wire
